// File: rtl/bqf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bqf_pkg;

    // Default widths of the sample and coefficient formats.
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // Configuration register file.
    localparam int NUM_COEFS = 5;
    localparam int CFG_IDX_W = 3;

    // Microprogram geometry.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] STEP_EMIT = 4'd4;
    localparam logic [STEP_W-1:0] STEP_LAST = 4'd8;

    // Coefficient selects, which are also the configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } coef_sel_t;

    // How the step counter advances.
    typedef enum logic [1:0] {
        COND_STEP,      // go to the following step
        COND_JUMP,      // always go to the jump target
        COND_WAIT_IN,   // jump to target unless a request is taken
        COND_WAIT_OUT   // jump to target while the output register is blocked
    } cond_t;

    // Second multiplier operand.
    typedef enum logic {
        OPND_X,
        OPND_Y
    } opnd_t;

    // Accumulator operation.
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_PROD_D1,
        ACC_PROD_D2,
        ACC_SUB,
        ACC_PROD
    } acc_op_t;

    // One control word of the microprogram.
    typedef struct packed {
        logic [STEP_W-1:0] target;
        cond_t             cond;
        coef_sel_t         coef;
        opnd_t             opnd;
        logic              mul_en;
        acc_op_t           acc_op;
        logic              x_ld;
        logic              y_ld;
        logic              d1_ld;
        logic              d2_ld;
        logic              out_ld;
    } ucw_t;

endpackage

`default_nettype wire

// File: rtl/bqf_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

module bqf_sequencer (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_take,
    input  wire logic                       out_busy,
    output bqf_pkg::ucw_t                   ucw,
    output logic [bqf_pkg::STEP_W-1:0]      step
);
    import bqf_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    // The program: one control word per step.
    function automatic ucw_t program_word(input logic [STEP_W-1:0] s);
        ucw_t w;
        w.target = STEP_IDLE;
        w.cond   = COND_STEP;
        w.coef   = COEF_B0;
        w.opnd   = OPND_X;
        w.mul_en = 1'b0;
        w.acc_op = ACC_HOLD;
        w.x_ld   = 1'b0;
        w.y_ld   = 1'b0;
        w.d1_ld  = 1'b0;
        w.d2_ld  = 1'b0;
        w.out_ld = 1'b0;
        case (s)
            4'd0:
            begin
                w.cond   = COND_WAIT_IN;
                w.target = STEP_IDLE;
                w.x_ld   = 1'b1;
            end
            4'd1:
            begin
                w.mul_en = 1'b1;
                w.coef   = COEF_B0;
                w.opnd   = OPND_X;
            end
            4'd2:
            begin
                w.acc_op = ACC_PROD_D1;
                w.mul_en = 1'b1;
                w.coef   = COEF_B1;
                w.opnd   = OPND_X;
            end
            4'd3:
            begin
                w.y_ld   = 1'b1;
                w.acc_op = ACC_PROD_D2;
            end
            4'd4:
            begin
                w.mul_en = 1'b1;
                w.coef   = COEF_A1;
                w.opnd   = OPND_Y;
                w.out_ld = 1'b1;
                w.cond   = COND_WAIT_OUT;
                w.target = STEP_EMIT;
            end
            4'd5:
            begin
                w.acc_op = ACC_SUB;
                w.mul_en = 1'b1;
                w.coef   = COEF_B2;
                w.opnd   = OPND_X;
            end
            4'd6:
            begin
                w.d1_ld  = 1'b1;
                w.acc_op = ACC_PROD;
                w.mul_en = 1'b1;
                w.coef   = COEF_A2;
                w.opnd   = OPND_Y;
            end
            4'd7:
            begin
                w.acc_op = ACC_SUB;
            end
            4'd8:
            begin
                w.d2_ld  = 1'b1;
                w.cond   = COND_JUMP;
                w.target = STEP_IDLE;
            end
            default:
            begin
                w.cond   = COND_JUMP;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    assign ucw  = program_word(step_reg);
    assign step = step_reg;

    always_comb
    begin
        case (ucw.cond)
            COND_STEP:     step_next = step_reg + 1'b1;
            COND_JUMP:     step_next = ucw.target;
            COND_WAIT_IN:  step_next = in_take ? step_reg + 1'b1 : ucw.target;
            COND_WAIT_OUT: step_next = out_busy ? ucw.target : step_reg + 1'b1;
            default:       step_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/bqf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module bqf_datapath #(
    parameter int SAMPLE_BITS    = bqf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [bqf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [COEF_FRAC_BITS+1:0]           cfg_data,
    input  wire bqf_pkg::ucw_t                       ucw,
    input  wire logic                                in_take,
    input  wire logic signed [SAMPLE_BITS-1:0]       sample_in,
    output logic signed [SAMPLE_BITS-1:0]            y
);
    import bqf_pkg::*;

    localparam int COEF_BITS   = COEF_FRAC_BITS + 2;
    localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
    localparam int STATE_RAW   = SAMPLE_BITS + COEF_FRAC_BITS + 4;
    localparam int STATE_BITS  = (STATE_RAW > 63) ? 63 : STATE_RAW;
    localparam int ACC_W       = ((PROD_W > STATE_BITS) ? PROD_W : STATE_BITS) + 3;

    localparam logic signed [ACC_W-1:0] ST_MAX =
        {{(ACC_W-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ST_MIN = ~ST_MAX;
    localparam logic signed [ACC_W-1:0] SMP_MAX =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMP_MIN = ~SMP_MAX;
    localparam logic signed [ACC_W-1:0] ROUND_K = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [COEF_BITS-1:0]    COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

    logic signed [COEF_BITS-1:0]   coef_reg [NUM_COEFS];
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       acc_next;
    logic signed [STATE_BITS-1:0]  d1_reg;
    logic signed [STATE_BITS-1:0]  d2_reg;

    logic signed [COEF_BITS-1:0]   mul_a;
    logic signed [SAMPLE_BITS-1:0] mul_b;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [ACC_W-1:0]       prod_ext;
    logic signed [ACC_W-1:0]       d1_ext;
    logic signed [ACC_W-1:0]       d2_ext;
    logic signed [ACC_W-1:0]       rnd_sum;
    logic signed [ACC_W-1:0]       rnd_shift;
    logic signed [SAMPLE_BITS-1:0] y_next;
    logic signed [STATE_BITS-1:0]  st_clamped;
    logic                          cfg_hit;

    assign cfg_hit = cfg_we && (cfg_index < CFG_IDX_W'(NUM_COEFS));

    // Shared multiplier.
    assign mul_a     = coef_reg[ucw.coef];
    assign mul_b     = (ucw.opnd == OPND_Y) ? y_reg : x_reg;
    assign prod_next = mul_a * mul_b;

    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign d1_ext   = {{(ACC_W-STATE_BITS){d1_reg[STATE_BITS-1]}}, d1_reg};
    assign d2_ext   = {{(ACC_W-STATE_BITS){d2_reg[STATE_BITS-1]}}, d2_reg};

    always_comb
    begin
        case (ucw.acc_op)
            ACC_HOLD:    acc_next = acc_reg;
            ACC_PROD_D1: acc_next = prod_ext + d1_ext;
            ACC_PROD_D2: acc_next = prod_ext + d2_ext;
            ACC_SUB:     acc_next = acc_reg - prod_ext;
            ACC_PROD:    acc_next = prod_ext;
            default:     acc_next = acc_reg;
        endcase
    end

    // Round half up, then saturate to the sample range.
    assign rnd_sum   = acc_reg + ROUND_K;
    assign rnd_shift = rnd_sum >>> COEF_FRAC_BITS;

    always_comb
    begin
        if (rnd_shift > SMP_MAX)
        begin
            y_next = SMP_MAX[SAMPLE_BITS-1:0];
        end
        else if (rnd_shift < SMP_MIN)
        begin
            y_next = SMP_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            y_next = rnd_shift[SAMPLE_BITS-1:0];
        end
    end

    // Saturate the accumulator to the state range.
    always_comb
    begin
        if (acc_reg > ST_MAX)
        begin
            st_clamped = ST_MAX[STATE_BITS-1:0];
        end
        else if (acc_reg < ST_MIN)
        begin
            st_clamped = ST_MIN[STATE_BITS-1:0];
        end
        else
        begin
            st_clamped = acc_reg[STATE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Pass-through: b0 is one, every other coefficient is zero.
            for (int i = 0; i < NUM_COEFS; i++)
            begin
                coef_reg[i] <= (i == int'(COEF_B0)) ? COEF_ONE : '0;
            end
            d1_reg <= '0;
            d2_reg <= '0;
        end
        else if (cfg_hit)
        begin
            // Any coefficient write restarts the filter from a clean state.
            coef_reg[cfg_index] <= cfg_data;
            d1_reg <= '0;
            d2_reg <= '0;
        end
        else
        begin
            if (ucw.d1_ld)
            begin
                d1_reg <= st_clamped;
            end
            if (ucw.d2_ld)
            begin
                d2_reg <= st_clamped;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ucw.x_ld && in_take)
        begin
            x_reg <= sample_in;
        end
        if (ucw.y_ld)
        begin
            y_reg <= y_next;
        end
        if (ucw.mul_en)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    assign y = y_reg;

endmodule

`default_nettype wire

// File: rtl/biquad_iir_filter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Biquad IIR section, transposed direct form II, fixed point.
// Input channel: sample_in with in_valid; the block raises in_stall while it
// works on a request, and a request is taken when in_valid is high and
// in_stall is low. Output channel: sample_out with out_valid; the receiver
// holds the result with out_stall.
// Coefficients b0, b1, b2, a1, a2 (signed Q2.16) are written through
// cfg_we / cfg_index / cfg_data while the block is idle; every write clears
// both delay registers. Indexes beyond a2 are ignored.
// A nine-step microprogram drives one shared multiplier that forms the five
// products of a sample, so a new request is taken only once the program is
// back at its idle step. The result is registered at the output step.
// If the output register still holds an untaken result when the next one
// is ready, the program waits at its output step until the receiver takes
// it, and the input side stays stalled for that long.
// Reset restores pass-through coefficients (b0 = 1.0), clears both delay
// registers and empties the output register.
module biquad_iir_filter_unit #(
    parameter int SAMPLE_BITS    = bqf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [bqf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [COEF_FRAC_BITS+1:0]      cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]  sample_in,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [SAMPLE_BITS-1:0]       sample_out
);
    import bqf_pkg::*;

    ucw_t                          ucw;
    logic [STEP_W-1:0]             step;
    logic                          in_take;
    logic                          out_busy;
    logic                          out_load;
    logic signed [SAMPLE_BITS-1:0] y;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;

    // The input side is open only while the program sits at its idle step.
    assign in_stall = (step != STEP_IDLE);
    assign in_take  = in_valid && !in_stall;

    // The output register is blocked while it holds a result the receiver
    // has not taken; a result taken in this cycle frees it for a new one.
    assign out_busy = out_valid_reg && out_stall;
    assign out_load = ucw.out_ld && !out_busy;

    bqf_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_take  (in_take),
        .out_busy (out_busy),
        .ucw      (ucw),
        .step     (step)
    );

    bqf_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ucw       (ucw),
        .in_take   (in_take),
        .sample_in (sample_in),
        .y         (y)
    );

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            sample_out_reg <= y;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    // A taken request starts the program, which closes the input side.
    a_take_starts_program: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_stall)
        else $error("request taken but program did not start");

    // A new result appears only from the output step of the program.
    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(step == STEP_EMIT))
        else $error("result raised outside the output step");

    // The step counter never leaves the program.
    a_step_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        step <= STEP_LAST)
        else $error("step counter beyond the last program step");

endmodule

`default_nettype wire

// File: sim/biquad_response_check.sv
`timescale 1ns / 1ps

// Watches the configuration port and both request channels of the biquad,
// keeps its own fixed-point copy of the filter and compares every output
// request against the value predicted for the oldest pending input.
module biquad_response_check #(
    parameter int SAMPLE_BITS    = bqf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bqf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [COEF_FRAC_BITS+1:0]         cfg_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     sample_in,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [SAMPLE_BITS-1:0]     sample_out,
    output int                                fail_count,
    output int                                pending_results
);
    import bqf_pkg::*;

    localparam int STATE_BITS = (SAMPLE_BITS + COEF_FRAC_BITS + 4 > 63) ?
                                63 : SAMPLE_BITS + COEF_FRAC_BITS + 4;

    longint                        coef [NUM_COEFS];
    longint                        delay_one;
    longint                        delay_two;
    logic signed [SAMPLE_BITS-1:0] expected_out [$];
    logic signed [SAMPLE_BITS-1:0] want;

    function automatic longint clamp_to(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // One sample through the section. All products and sums stay far below
    // 64 bits at these widths, so only the sample and state clamps matter.
    function automatic logic signed [SAMPLE_BITS-1:0] filter_step(
        logic signed [SAMPLE_BITS-1:0] x_in
    );
        longint x;
        longint acc;
        longint y;
        longint d1_next;
        x   = longint'(x_in);
        acc = coef[COEF_B0] * x + delay_one;
        // Round half up, then floor through the arithmetic shift.
        y = clamp_to((acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS,
                     SAMPLE_BITS);
        d1_next   = clamp_to(coef[COEF_B1] * x - coef[COEF_A1] * y + delay_two,
                             STATE_BITS);
        delay_two = clamp_to(coef[COEF_B2] * x - coef[COEF_A2] * y, STATE_BITS);
        delay_one = d1_next;
        return y[SAMPLE_BITS-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef[COEF_B0] = longint'(1) <<< COEF_FRAC_BITS;
            coef[COEF_B1] = 0;
            coef[COEF_B2] = 0;
            coef[COEF_A1] = 0;
            coef[COEF_A2] = 0;
            delay_one     = 0;
            delay_two     = 0;
            expected_out.delete();
            fail_count      = 0;
            pending_results = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_out.size() == 0)
                begin
                    $error("sample_out: expected no request, got %0d", sample_out);
                    fail_count++;
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (sample_out !== want)
                    begin
                        $error("sample_out: expected %0d, got %0d", want, sample_out);
                        fail_count++;
                    end
                end
            end
            // Writes to unused indexes leave both coefficients and state alone.
            if (cfg_we && cfg_index < NUM_COEFS)
            begin
                coef[cfg_index] = longint'($signed(cfg_data));
                delay_one       = 0;
                delay_two       = 0;
            end
            if (in_valid && !in_stall)
                expected_out.push_back(filter_step(sample_in));
            pending_results = expected_out.size();
        end
    end

endmodule

// File: sim/tb_biquad_iir_filter_unit.sv
`timescale 1ns / 1ps

// Top of the biquad bench. It only produces stimulus: coefficient settings,
// input requests with random gaps and random output stalls. The response
// check beside the block predicts and compares, and hands back the number
// of failures and the number of results still owed.
module tb_biquad_iir_filter_unit;
    import bqf_pkg::*;

    localparam int SAMPLE_W      = SAMPLE_BITS_DEF;
    localparam int COEF_W        = COEF_FRAC_BITS_DEF + 2;
    localparam int COEF_ONE      = 1 << COEF_FRAC_BITS_DEF;
    localparam int COEF_MAX      = (1 << (COEF_W - 1)) - 1;
    localparam int COEF_MIN      = -(1 << (COEF_W - 1));
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX =
        SAMPLE_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN =
        SAMPLE_W'(-(1 << (SAMPLE_W - 1)));
    localparam int RANDOM_ITEMS  = 1350;
    // The microprogram runs nine steps per request; the delay registers are
    // written in the steps after the result, which this settle wait covers.
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 5000;

    // Coefficient set styles for the random phases.
    localparam int SET_STABLE  = 0;
    localparam int SET_FULL    = 1;
    localparam int SET_EXTREME = 2;
    localparam int SET_NEAR_ID = 3;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [COEF_W-1:0]          cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       in_taken;
    int                         fail_count;
    int                         pending_results;

    biquad_iir_filter_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

    biquad_response_check response_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sample_in       (sample_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sample_out      (sample_out),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous ceiling: the slowest legal run stays well under 2 ms.
    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Records at each rising edge whether the input request was taken, so the
    // driver can look at it on the following falling edge without a race.
    always @(posedge clk)
        in_taken <= in_valid && !in_stall;

    // Output side: long stall-free stretches, many short stalls and now and
    // then a long one, so stalls land on every step of the microprogram.
    initial
    begin
        int  pick;
        int  run_len;
        bit  hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                hold    = 1'b0;
                run_len = $urandom_range(1, 40);
            end
            else if (pick < 85)
            begin
                hold    = 1'b1;
                run_len = $urandom_range(1, 3);
            end
            else if (pick < 95)
            begin
                hold    = 1'b0;
                run_len = $urandom_range(1, 3);
            end
            else
            begin
                hold    = 1'b1;
                run_len = $urandom_range(10, 60);
            end
            out_stall <= hold;
            repeat (run_len) @(negedge clk);
        end
    end

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Mostly full-range samples, with the two extremes and small values
    // mixed in often enough to matter.
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return SAMPLE_W'(rand_between(-256, 255));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // One register write. The enable is dropped for a cycle afterwards so that
    // back-to-back writes never lower and raise it in the same time step.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[COEF_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_coefs(input int b0, input int b1, input int b2,
                              input int a1, input int a2);
        cfg_write(COEF_B0, b0);
        cfg_write(COEF_B1, b1);
        cfg_write(COEF_B2, b2);
        cfg_write(COEF_A1, a1);
        cfg_write(COEF_A2, a2);
    endtask

    // A write to an index past a2, which the block must ignore.
    task automatic unused_write();
        cfg_write(CFG_IDX_W'($urandom_range(NUM_COEFS, (1 << CFG_IDX_W) - 1)),
                  int'($urandom));
    endtask

    // Called on a falling edge; returns on the falling edge after the request
    // was taken, with valid still high.
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] x);
        in_valid  <= 1'b1;
        sample_in <= x;
        do
            @(negedge clk);
        while (!in_taken);
    endtask

    // Idle gap between input requests: usually none, sometimes a few
    // cycles, rarely a long one. Burst phases never idle.
    task automatic sender_gap(input bit burst);
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (burst || pick < 55)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Stop sending until every result has come back and the block has
    // finished updating its delay registers.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_random_coefs(input int style);
        int c [NUM_COEFS];
        int a1_lim;
        case (style)
            SET_STABLE:
            begin
                // Poles kept inside the stability triangle, with some margin.
                c[COEF_B0] = rand_between(-COEF_ONE / 2, COEF_ONE / 2);
                c[COEF_B1] = rand_between(-COEF_ONE / 2, COEF_ONE / 2);
                c[COEF_B2] = rand_between(-COEF_ONE / 2, COEF_ONE / 2);
                c[COEF_A2] = rand_between(0, COEF_ONE * 3 / 4);
                a1_lim     = (COEF_ONE + c[COEF_A2]) * 9 / 10;
                c[COEF_A1] = rand_between(-a1_lim, a1_lim);
            end
            SET_FULL:
            begin
                foreach (c[i])
                    c[i] = rand_between(COEF_MIN, COEF_MAX);
            end
            SET_EXTREME:
            begin
                foreach (c[i])
                begin
                    case ($urandom_range(0, 4))
                        0:       c[i] = COEF_MIN;
                        1:       c[i] = COEF_MAX;
                        2:       c[i] = COEF_ONE;
                        3:       c[i] = -COEF_ONE;
                        default: c[i] = 0;
                    endcase
                end
            end
            default:
            begin
                c[COEF_B0] = COEF_ONE + rand_between(-64, 64);
                c[COEF_B1] = rand_between(-256, 256);
                c[COEF_B2] = rand_between(-256, 256);
                c[COEF_A1] = rand_between(-256, 256);
                c[COEF_A2] = rand_between(-256, 256);
            end
        endcase
        load_coefs(c[COEF_B0], c[COEF_B1], c[COEF_B2], c[COEF_A1], c[COEF_A2]);
    endtask

    initial
    begin
        logic signed [SAMPLE_W-1:0] pass_list [7];
        int  random_sent;
        int  phase_len;
        int  style;
        int  wait_cycles;
        bit  burst;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        sample_in = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        // Reset coefficients pass samples straight through, extremes and
        // alternating bit patterns included.
        pass_list = '{16'sd0, SAMPLE_MAX, SAMPLE_MIN, 16'sd1, -16'sd1,
                      16'sh5555, 16'shAAAA};
        foreach (pass_list[i])
        begin
            push_sample(pass_list[i]);
            sender_gap(1'b0);
        end
        drain();

        // A gain of one half puts odd inputs exactly on the rounding boundary:
        // positive halves round up, negative halves round toward zero.
        load_coefs(COEF_ONE / 2, 0, 0, 0, 0);
        push_sample(1);
        push_sample(-1);
        push_sample(3);
        push_sample(-3);
        drain();

        // Build up state, then write to unused indexes: the state must survive,
        // so the zero inputs that follow still produce the delayed terms.
        load_coefs(COEF_ONE, COEF_ONE, COEF_ONE / 2, 0, 0);
        push_sample(1000);
        push_sample(2000);
        drain();
        unused_write();
        cfg_write(CFG_IDX_W'((1 << CFG_IDX_W) - 1), COEF_MAX);
        push_sample(0);
        push_sample(0);
        drain();

        // Largest gain drives the output into saturation both ways.
        load_coefs(COEF_MAX, 0, 0, 0, 0);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample(20000);
        drain();

        // Every coefficient at its most negative value with full-scale
        // inputs pushes the state as far as it can go, with saturated y
        // feeding back.
        load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        repeat (3) push_sample(SAMPLE_MIN);
        repeat (3) push_sample(SAMPLE_MAX);
        drain();

        // Random phases: each one programs a fresh coefficient set while the
        // block is idle, then streams samples through it. Now and then the
        // sender holds off until everything is back, sometimes followed by a
        // write that must be ignored.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            style     = $urandom_range(SET_STABLE, SET_NEAR_ID);
            burst     = ($urandom_range(0, 3) == 0);
            phase_len = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300) :
                                                      $urandom_range(10, 80);
            load_random_coefs(style);
            if ($urandom_range(0, 4) == 0)
                unused_write();
            for (int n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++)
            begin
                push_sample(rand_sample());
                random_sent++;
                if ($urandom_range(0, 49) == 0)
                begin
                    drain();
                    if ($urandom_range(0, 1) == 1)
                        unused_write();
                end
                else
                    sender_gap(burst);
            end
            drain();
        end

        // Wind down: wait for the last results, bounded, then let the block
        // settle before the verdict.
        in_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_results != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending_results != 0)
            $error("sample_out: %0d expected requests never arrived", pending_results);
        if (fail_count == 0 && pending_results == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
